@@ rtl/unsigned_decimal_to_ascii_macros.svh @@
`ifndef UNSIGNED_DECIMAL_TO_ASCII_MACROS_SVH
`define UNSIGNED_DECIMAL_TO_ASCII_MACROS_SVH

// Checked on every rising edge outside reset.
`define UDTA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset cycles included.
`define UDTA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/udta_pkg.sv @@
package udta_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int VALUE_BITS = 32;
   localparam int DIGIT_BITS = 6;
   localparam int LENGTH_BITS = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [DIGIT_BITS-1:0] ASCII_ZERO = 6'd48;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Decimal digits of the largest value of the given width: 1233/4096 is log10(2).
   function automatic int max_digits(input int width);
      return ((width * 1233) >>> 12) + 1;
   endfunction

   function automatic int count_bits(input int width);
      return $clog2(max_digits(width) + 1);
   endfunction

endpackage

@@ rtl/udta_front.sv @@
module udta_front #(
   parameter int VALUE_WIDTH = udta_pkg::DEFAULT_VALUE_WIDTH,
   localparam int DATA_W = udta_pkg::count_bits(VALUE_WIDTH)
                           + 4 * udta_pkg::max_digits(VALUE_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VALUE_WIDTH-1:0]    value,
   input  udta_pkg::queue_status_type queue_status,
   output logic                      busy,
   output logic                      push,
   output logic [DATA_W-1:0]         push_data
);
   import udta_pkg::*;

   localparam int STEP = 4;
   localparam int MAX_DIGITS = max_digits(VALUE_WIDTH);
   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int CNT_W = count_bits(VALUE_WIDTH);
   localparam int PAD_W = ((VALUE_WIDTH + STEP - 1) / STEP) * STEP;
   localparam int STEPS = PAD_W / STEP;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   localparam logic [1:0] FRONT_IDLE = 2'd0;
   localparam logic [1:0] FRONT_CONV = 2'd1;
   localparam logic [1:0] FRONT_PUSH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [PAD_W-1:0]  val_ff, val_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BCD_W-1:0]  bcd_step;
   logic [CNT_W-1:0]  len;
   logic [STEP-1:0]   top_bits;

   assign top_bits = val_ff[PAD_W-1 -: STEP];

   // Four rounds of shift-and-add-3 per cycle, most significant value bit first.
   always_comb begin
      bcd_step = bcd_ff;
      for (int s = 0; s < STEP; s++) begin
         for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_step[4*d +: 4] >= 4'd5) begin
               bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_W-2:0], top_bits[STEP-1-s]};
      end
   end

   // The run length is set by the highest nonzero digit; zero still gives one digit.
   always_comb begin
      len = CNT_W'(1);
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            len = CNT_W'(d + 1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      val_in = val_ff;
      bcd_in = bcd_ff;
      step_in = step_ff;
      push = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (start) begin
               val_in = PAD_W'(value);
               bcd_in = '0;
               step_in = STEP_W'(STEPS - 1);
               state_in = FRONT_CONV;
            end
         end
         FRONT_CONV: begin
            val_in = val_ff << STEP;
            bcd_in = bcd_step;
            if (step_ff == '0) begin
               state_in = FRONT_PUSH;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         FRONT_PUSH: begin
            if (!queue_status.full) begin
               push = 1'b1;
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != FRONT_IDLE);
   assign push_data = {len, bcd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      bcd_ff <= bcd_in;
      step_ff <= step_in;
   end

endmodule

@@ rtl/udta_queue.sv @@
module udta_queue #(
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output udta_pkg::queue_status_type status
);
   import udta_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/udta_back.sv @@
module udta_back #(
   parameter int VALUE_WIDTH = udta_pkg::DEFAULT_VALUE_WIDTH,
   localparam int DATA_W = udta_pkg::count_bits(VALUE_WIDTH)
                           + 4 * udta_pkg::max_digits(VALUE_WIDTH)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  udta_pkg::queue_status_type      queue_status,
   input  logic [DATA_W-1:0]               pop_data,
   output logic                            pop,
   output logic                            rsp_valid,
   output logic [udta_pkg::DIGIT_BITS-1:0] rsp_digit_char,
   output logic                            rsp_last,
   output logic [udta_pkg::LENGTH_BITS-1:0] rsp_total_length
);
   import udta_pkg::*;

   localparam int MAX_DIGITS = max_digits(VALUE_WIDTH);
   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int CNT_W = count_bits(VALUE_WIDTH);
   localparam int IDX_W = $clog2(MAX_DIGITS);

   logic                   active_ff, active_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       len_ff, len_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [CNT_W-1:0]       pop_len;
   logic [3:0]             digit;
   logic [CNT_W+LENGTH_BITS-1:0] len_wide;

   assign pop_len = pop_data[DATA_W-1 -: CNT_W];

   // A new run is taken as soon as the current one shows its final digit.
   assign pop = !queue_status.empty && (!active_ff || idx_ff == '0);

   always_comb begin
      active_in = active_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      bcd_in = bcd_ff;
      if (pop) begin
         active_in = 1'b1;
         idx_in = IDX_W'(pop_len - 1'b1);
         len_in = pop_len;
         bcd_in = pop_data[BCD_W-1:0];
      end else if (active_ff) begin
         if (idx_ff == '0) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   assign digit = bcd_ff[{idx_ff, 2'b00} +: 4];
   assign len_wide = {{LENGTH_BITS{1'b0}}, len_ff};

   assign rsp_valid = active_ff;
   assign rsp_digit_char = ASCII_ZERO + {{(DIGIT_BITS-4){1'b0}}, digit};
   assign rsp_last = active_ff && (idx_ff == '0);
   assign rsp_total_length = rsp_last ? len_wide[LENGTH_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      bcd_ff <= bcd_in;
   end

endmodule

@@ rtl/unsigned_decimal_to_ascii.sv @@
// Converts an unsigned value to decimal ASCII text, one character per word, most
// significant digit first and without leading zeros; zero gives a single '0'. A value
// is taken when start is high and busy is low. The converter works four bits per
// cycle, and busy stays high after each accepted word until its result is pushed into
// the queue, so a new value is only taken once the previous one is in it. Finished
// conversions wait in a two-entry queue; the output side then shows each run one
// character per cycle on consecutive cycles, with rsp_valid as the strobe. The receiver
// cannot stall: each character is on the rsp_ ports for exactly one cycle.
// rsp_total_length holds the character count on the word with rsp_last set and zero
// otherwise. When the queue is full, busy stays high until a run starts to drain.
module unsigned_decimal_to_ascii #(
   parameter int VALUE_WIDTH = udta_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [udta_pkg::VALUE_BITS-1:0]  req_value,
   output logic                             rsp_valid,
   output logic [udta_pkg::DIGIT_BITS-1:0]  rsp_digit_char,
   output logic                             rsp_last,
   output logic [udta_pkg::LENGTH_BITS-1:0] rsp_total_length
);
   import udta_pkg::*;

   localparam int DATA_W = count_bits(VALUE_WIDTH) + 4 * max_digits(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] value;
   logic                   push;
   logic                   pop;
   logic [DATA_W-1:0]      push_data;
   logic [DATA_W-1:0]      pop_data;
   queue_status_type       queue_status;

   // Bits above the configured width are dropped.
   assign value = VALUE_WIDTH'(req_value);

   udta_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .value(value),
      .queue_status(queue_status),
      .busy(busy),
      .push(push),
      .push_data(push_data)
   );

   udta_queue #(
      .WIDTH(DATA_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .pop_data(pop_data),
      .status(queue_status)
   );

   udta_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_status(queue_status),
      .pop_data(pop_data),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last(rsp_last),
      .rsp_total_length(rsp_total_length)
   );

endmodule

@@ rtl/udta_checker.sv @@
`include "unsigned_decimal_to_ascii_macros.svh"

module udta_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [udta_pkg::DIGIT_BITS-1:0]  rsp_digit_char,
   input logic                             rsp_last,
   input logic [udta_pkg::LENGTH_BITS-1:0] rsp_total_length
);
   import udta_pkg::*;

   // An accepted word always starts a conversion.
   `UDTA_ASSERT(accept_sets_busy, start && !busy |=> busy, "busy not raised after accept")

   // A run goes out on consecutive cycles until its final character.
   `UDTA_ASSERT(run_unbroken, rsp_valid && !rsp_last |=> rsp_valid, "gap inside a run")

   // Only the final character carries the length.
   `UDTA_ASSERT(length_only_last, rsp_valid && !rsp_last |-> rsp_total_length == '0,
      "length on a non-final character")

   // A zero that is not the final character can never open a run.
   `UDTA_ASSERT(no_leading_zero,
      rsp_valid && rsp_digit_char == ASCII_ZERO && !rsp_last
         |-> $past(rsp_valid) && !$past(rsp_last),
      "leading zero in a run")

   // Reset leaves nothing in flight.
   `UDTA_ASSERT_ALWAYS(reset_clears, reset |=> !rsp_valid && !busy, "activity after reset")

endmodule

bind unsigned_decimal_to_ascii udta_checker u_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_digit_char(rsp_digit_char),
   .rsp_last(rsp_last),
   .rsp_total_length(rsp_total_length)
);
